// ----- src/phhw_pkg.sv -----
package phhw_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PEAK_W   = 15;
  localparam int IDX_W    = 11;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  peak_index;
    logic [PEAK_W-1:0] peak_value;
    logic [IDX_W-1:0]  rise_index;
    logic [IDX_W-1:0]  fall_index;
    logic [IDX_W-1:0]  width;
    logic              rise_found;
    logic              fall_found;
    logic              overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } scan_state_t;

endpackage

// ----- src/phhw_front.sv -----
module phhw_front #(
  parameter int MAX_SAMPLES = 2048
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  phhw_pkg::in_item_t                       in_data,
  input  logic                                     done,
  input  logic                                     q_full,
  output logic                                     q_push,
  output logic [$clog2(MAX_SAMPLES+1)-1:0]         job_count,
  output logic [phhw_pkg::PEAK_W-1:0]              job_peak,
  output logic [$clog2(MAX_SAMPLES)-1:0]           job_peak_idx,
  output logic                                     job_drop,
  output logic                                     wr_en,
  output logic [$clog2(MAX_SAMPLES)-1:0]           wr_addr,
  output logic [phhw_pkg::SAMPLE_W-1:0]            wr_data
);
  import phhw_pkg::*;

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  logic [CW-1:0]     count_r, count_nxt;
  logic [PEAK_W-1:0] peak_r, peak_nxt;
  logic [AW-1:0]     pidx_r, pidx_nxt;
  logic              drop_r, drop_nxt;
  logic              busy_r, busy_nxt;
  logic              full;
  logic              acc;

  assign full     = (count_r == CW'(MAX_SAMPLES));
  assign in_stall = busy_r || q_full;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    count_nxt    = count_r;
    peak_nxt     = peak_r;
    pidx_nxt     = pidx_r;
    drop_nxt     = drop_r;
    busy_nxt     = busy_r;
    wr_en        = 1'b0;
    wr_addr      = count_r[AW-1:0];
    wr_data      = in_data.sample;
    q_push       = 1'b0;
    if (acc) begin
      if (!full) begin
        wr_en = 1'b1;
        // strictly larger and positive
        if (!in_data.sample[SAMPLE_W-1] && (in_data.sample[PEAK_W-1:0] > peak_r)) begin
          peak_nxt = in_data.sample[PEAK_W-1:0];
          pidx_nxt = count_r[AW-1:0];
        end
        count_nxt = count_r + CW'(1);
      end else begin
        drop_nxt = 1'b1;
      end
    end
    job_count    = count_nxt;
    job_peak     = peak_nxt;
    job_peak_idx = pidx_nxt;
    job_drop     = drop_nxt;
    if (acc && in_data.last) begin
      q_push    = 1'b1;
      busy_nxt  = 1'b1;
      count_nxt = '0;
      peak_nxt  = '0;
      pidx_nxt  = '0;
      drop_nxt  = 1'b0;
    end
    if (done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      peak_r  <= '0;
      pidx_r  <= '0;
      drop_r  <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      peak_r  <= peak_nxt;
      pidx_r  <= pidx_nxt;
      drop_r  <= drop_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

// ----- src/phhw_queue.sv -----
module phhw_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);
  import phhw_pkg::*;

  logic [DATA_W-1:0] slot_r [2];
  logic              wp_r, wp_nxt;
  logic              rp_r, rp_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? !wp_r : wp_r;
    rp_nxt  = do_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

// ----- src/phhw_back.sv -----
module phhw_back #(
  parameter int MAX_SAMPLES = 2048
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     wr_en,
  input  logic [$clog2(MAX_SAMPLES)-1:0]           wr_addr,
  input  logic [phhw_pkg::SAMPLE_W-1:0]            wr_data,
  input  logic                                     q_empty,
  output logic                                     q_pop,
  input  logic [$clog2(MAX_SAMPLES+1)-1:0]         job_count,
  input  logic [phhw_pkg::PEAK_W-1:0]              job_peak,
  input  logic [$clog2(MAX_SAMPLES)-1:0]           job_peak_idx,
  input  logic                                     job_drop,
  output logic                                     done,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output phhw_pkg::out_item_t                      out_data
);
  import phhw_pkg::*;

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];
  logic [SAMPLE_W-1:0] rdata_r;
  logic [AW-1:0]       rd_addr;

  scan_state_t   state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PEAK_W-1:0] peak_r, peak_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  logic          drop_r, drop_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          vld_r, vld_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          prev_ge_r, prev_ge_nxt;
  logic          rise_r, rise_nxt;
  logic          fall_r, fall_nxt;
  logic [AW-1:0] rise_at_r, rise_at_nxt;
  logic [AW-1:0] fall_at_r, fall_at_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;
  logic          cur_ge;
  logic [AW-1:0] span;

  assign rd_addr   = ptr_r[AW-1:0];
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // exact half-height test: 2*s >= peak
  assign cur_ge = ($signed({rdata_r, 1'b0}) >= $signed({2'b00, peak_r}));
  assign span   = fall_r ? (fall_at_r - rise_at_r) : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    peak_nxt      = peak_r;
    pidx_nxt      = pidx_r;
    drop_nxt      = drop_r;
    ptr_nxt       = ptr_r;
    vld_nxt       = 1'b0;
    idx_nxt       = idx_r;
    prev_ge_nxt   = prev_ge_r;
    rise_nxt      = rise_r;
    fall_nxt      = fall_r;
    rise_at_nxt   = rise_at_r;
    fall_at_nxt   = fall_at_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    q_pop         = 1'b0;
    done          = 1'b0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          cnt_nxt     = job_count;
          peak_nxt    = job_peak;
          pidx_nxt    = job_peak_idx;
          drop_nxt    = job_drop;
          ptr_nxt     = '0;
          rise_nxt    = 1'b0;
          fall_nxt    = 1'b0;
          rise_at_nxt = '0;
          fall_at_nxt = '0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ptr_r < cnt_r) begin
          ptr_nxt = ptr_r + CW'(1);
          vld_nxt = 1'b1;
          idx_nxt = ptr_r[AW-1:0];
        end else if (!vld_r) begin
          state_nxt = ST_FIN;
        end
        if (vld_r) begin
          prev_ge_nxt = cur_ge;
          if (idx_r != '0) begin
            if (!rise_r && !prev_ge_r && cur_ge) begin
              rise_nxt    = 1'b1;
              rise_at_nxt = idx_r;
            end
            if (rise_r && !fall_r && prev_ge_r && !cur_ge) begin
              fall_nxt    = 1'b1;
              fall_at_nxt = idx_r;
            end
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.peak_index = IDX_W'(pidx_r);
          out_nxt.peak_value = peak_r;
          out_nxt.rise_index = IDX_W'(rise_at_r);
          out_nxt.fall_index = IDX_W'(fall_at_r);
          out_nxt.width      = IDX_W'(span);
          out_nxt.rise_found = rise_r;
          out_nxt.fall_found = fall_r;
          out_nxt.overflow   = drop_r;
          out_valid_nxt      = 1'b1;
          done               = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    peak_r    <= peak_nxt;
    pidx_r    <= pidx_nxt;
    drop_r    <= drop_nxt;
    ptr_r     <= ptr_nxt;
    idx_r     <= idx_nxt;
    prev_ge_r <= prev_ge_nxt;
    rise_r    <= rise_nxt;
    fall_r    <= fall_nxt;
    rise_at_r <= rise_at_nxt;
    fall_at_r <= fall_at_nxt;
    out_r     <= out_nxt;
  end

endmodule

// ----- src/pulse_half_height_width.sv -----
// pulse half-height width measurement
//
// in channel: one signed sample per item, last marks the end of a recording.
// samples go into an on-chip store at one item per cycle while in_stall is
// low; the running peak (first strictly largest positive sample) is tracked.
// samples beyond the store depth are dropped and reported through overflow.
// out channel: one result item per recording, given after the last sample:
// peak index and value, first rise and fall crossing of half the peak,
// width and found flags.
// scan: after the item marked last, the back end scans the n stored samples
// at one store read per cycle through the single read port of the store.
// the front end takes no new sample from the last item until the result is
// in the output register.
// a stalled output holds its result; the front end resumes as soon as the
// result is registered, so the next recording may load while it waits.
// reset: synchronous, active low; clears the run state, the job queue and the
// output valid. store contents are not cleared and never scanned unwritten.
module pulse_half_height_width #(
  parameter int MAX_SAMPLES = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  phhw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output phhw_pkg::out_item_t out_data
);
  import phhw_pkg::*;

  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int CW    = $clog2(MAX_SAMPLES + 1);
  localparam int JOB_W = CW + PEAK_W + AW + 1;

  // front to back: store writes and measurement jobs
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [SAMPLE_W-1:0] wr_data;
  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_empty;
  logic                done;
  logic [JOB_W-1:0]    q_in;
  logic [JOB_W-1:0]    q_out;

  // job snapshot taken as the last item is accepted
  logic [CW-1:0]     f_count, b_count;
  logic [PEAK_W-1:0] f_peak, b_peak;
  logic [AW-1:0]     f_pidx, b_pidx;
  logic              f_drop, b_drop;

  assign q_in = {f_count, f_peak, f_pidx, f_drop};
  assign {b_count, b_peak, b_pidx, b_drop} = q_out;

  phhw_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .done         (done),
    .q_full       (q_full),
    .q_push       (q_push),
    .job_count    (f_count),
    .job_peak     (f_peak),
    .job_peak_idx (f_pidx),
    .job_drop     (f_drop),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  // short job queue between the front end and the scan
  phhw_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // store and crossing scan
  phhw_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .job_count    (b_count),
    .job_peak     (b_peak),
    .job_peak_idx (b_pidx),
    .job_drop     (b_drop),
    .done         (done),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

  // a job is never pushed into a full queue
  a_no_q_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("job pushed into full queue");

  // the store is locked once a recording ends
  a_lock_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.last) |=> in_stall)
    else $error("input taken while a scan is pending");

  // a fall is only reported after a rise
  a_fall_needs_rise: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.fall_found || out_data.rise_found))
    else $error("fall without rise");

  // no fall means zero width and zero fall index
  a_no_fall_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.fall_found) |->
      (out_data.width == '0 && out_data.fall_index == '0))
    else $error("width or fall index set without a fall");

endmodule
